[sv/trs_mm_pkg.sv]
// Shared constants and helpers for the TRS model matrix composer.
// No dependencies; every module of the block imports it.
package trs_mm_pkg;

  // Item field widths
  localparam int SHIFT_W   = 32;
  localparam int ANGLE_W   = 16;
  localparam int STRETCH_W = 16;
  localparam int ENTRY_W   = 16;
  localparam int S_DATA_W  = 3 * SHIFT_W + 3 * ANGLE_W + 3 * STRETCH_W;
  localparam int MAT_W     = 9 * ENTRY_W;
  localparam int M_DATA_W  = MAT_W + 3 * SHIFT_W;

  // Pipeline depths of the two datapath units
  localparam int SIN_LAT = 9;
  localparam int ENT_LAT = 5;

  // Sine polynomial, Q30 fraction of a quarter turn
  localparam int         QSHIFT     = 30;
  localparam int         POLY_W     = 31;
  localparam int         POLY_TERMS = 5;
  localparam logic [30:0] POLY_C1  = 31'd1686629713;
  localparam logic [30:0] POLY_C3  = 31'd693598668;
  localparam logic [30:0] POLY_C5  = 31'd85569306;
  localparam logic [30:0] POLY_C7  = 31'd5026995;
  localparam logic [30:0] POLY_C9  = 31'd172272;
  localparam logic [30:0] POLY_C11 = 31'd3864;

  // Horner coefficient used at step k, innermost first
  function automatic logic [30:0] poly_coef(input int k);
    logic [30:0] c;
    case (k)
      0:       c = POLY_C9;
      1:       c = POLY_C7;
      2:       c = POLY_C5;
      3:       c = POLY_C3;
      default: c = POLY_C1;
    endcase
    return c;
  endfunction

endpackage

[sv/trs_model_matrix_composer.sv]
// TRS model matrix composer: from a translation (Q16.16), three Euler angles (binary
// angle, 2^ANGLE_BITS per turn) and three scale factors (Q4.12) it gives the top three
// rows of T*Rx*Ry*Rz*S: nine rotation-scale entries rounded and saturated to Q4.12, and
// the translation column unchanged. The block takes one item every clock, and each result
// passes through nine stages of polynomial sine (at most one multiplier a stage, six lanes
// for the sines and cosines) and five stages of entry products, rounding and saturation.
// The whole pipeline advances together; when the result at the output is not taken, every
// stage and s_tready hold.
// Depends on trs_mm_pkg, trs_mm_sine and trs_mm_entry.
module trs_model_matrix_composer #(
  parameter int ANGLE_BITS         = 16,
  parameter int TRIG_FRACTION_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // shift_x, shift_y, shift_z, angle_about_x/y/z, stretch_x/y/z
  input  logic [trs_mm_pkg::S_DATA_W-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // row0_col0 .. row2_col2, offset_x, offset_y, offset_z
  output logic [trs_mm_pkg::M_DATA_W-1:0] m_tdata
);
  import trs_mm_pkg::*;

  localparam int F     = TRIG_FRACTION_BITS;
  localparam int DEPTH = SIN_LAT + ENT_LAT;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic signed [F+1:0] TRIG_ONE = (F+2)'(1) <<< F;

  logic                        en;
  logic [DEPTH-1:0]            vld;
  logic [3*SHIFT_W-1:0]        sh_dly [0:DEPTH-1];
  logic [3*STRETCH_W-1:0]      k_dly  [0:SIN_LAT-1];
  logic signed [F+1:0]         sin_v  [0:2];
  logic signed [F+1:0]         cos_v  [0:2];
  logic [MAT_W-1:0]            mat;

  // Advance everything when the output stage is empty or being taken
  assign en       = !vld[DEPTH-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[DEPTH-1];
  assign m_tdata  = {sh_dly[DEPTH-1], mat};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  // Carry translation and scale alongside the trig lanes
  always_ff @(posedge clk) begin
    if (en) begin
      sh_dly[0] <= s_tdata[3*SHIFT_W-1:0];
      k_dly[0]  <= s_tdata[S_DATA_W-1 -: 3*STRETCH_W];
      for (int i = 1; i < DEPTH; i++) begin
        sh_dly[i] <= sh_dly[i-1];
      end
      for (int i = 1; i < SIN_LAT; i++) begin
        k_dly[i] <= k_dly[i-1];
      end
    end
  end

  // Sine and cosine lanes for each axis; cosine is a quarter turn ahead
  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    logic [ANGLE_BITS-1:0] ang;
    logic [ANGLE_BITS-1:0] ang_c;

    assign ang   = ANGLE_BITS'(s_tdata[3*SHIFT_W + ax*ANGLE_W +: ANGLE_W]);
    assign ang_c = ang + QUARTER;

    trs_mm_sine #(
      .ANGLE_BITS         (ANGLE_BITS),
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
    ) u_sin (
      .clk   (clk),
      .en    (en),
      .angle (ang),
      .sine  (sin_v[ax])
    );

    trs_mm_sine #(
      .ANGLE_BITS         (ANGLE_BITS),
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
    ) u_cos (
      .clk   (clk),
      .en    (en),
      .angle (ang_c),
      .sine  (cos_v[ax])
    );
  end

  trs_mm_entry #(
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
  ) u_entry (
    .clk     (clk),
    .en      (en),
    .sx      (sin_v[0]),
    .cx      (cos_v[0]),
    .sy      (sin_v[1]),
    .cy      (cos_v[1]),
    .sz      (sin_v[2]),
    .cz      (cos_v[2]),
    .stretch (k_dly[SIN_LAT-1]),
    .mat     (mat)
  );

  // An accepted item occupies the first stage next cycle
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted item missing from first stage");

  // A held result must stall the input side
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  // The x-axis sine and z-axis cosine stay within one in magnitude
  a_trig: assert property (@(posedge clk) disable iff (rst)
    vld[SIN_LAT-1] |-> (sin_v[0] <= TRIG_ONE) && (sin_v[0] >= -TRIG_ONE)
                    && (cos_v[2] <= TRIG_ONE) && (cos_v[2] >= -TRIG_ONE))
    else $error("trig value out of range");

endmodule

[sv/trs_mm_sine.sv]
// Pipelined fixed-point sine of a binary angle, nine register stages.
// Depends on trs_mm_pkg for the polynomial constants.
module trs_mm_sine #(
  parameter int ANGLE_BITS         = 16,
  parameter int TRIG_FRACTION_BITS = 14
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [ANGLE_BITS-1:0]           angle,
  output logic signed [TRIG_FRACTION_BITS+1:0] sine
);
  import trs_mm_pkg::*;

  localparam int F  = TRIG_FRACTION_BITS;
  localparam int RW = ANGLE_BITS - 1;
  localparam logic [RW-1:0] QUARTER = RW'(1) << (ANGLE_BITS - 2);

  logic [1:0]        quad;
  logic [RW-1:0]     rem;
  logic [RW-1:0]     refl;
  logic [POLY_W-1:0] x_in;

  logic [POLY_W-1:0] x_q   [0:6];
  logic              neg_q [0:7];
  logic [POLY_W-1:0] z_q   [1:5];
  logic [POLY_W-1:0] p_q   [2:6];
  logic [2*POLY_W-1:0] pr  [0:POLY_TERMS-1];
  logic [2*POLY_W-1:0] sq;
  logic [2*POLY_W-1:0] fin;
  logic [POLY_W-1:0] s_q;
  logic [POLY_W:0]   rnd;
  logic [F+1:0]      mag;

  // Fold the angle into the first quadrant
  assign quad = angle[ANGLE_BITS-1 -: 2];
  assign rem  = RW'(angle[ANGLE_BITS-3:0]);
  assign refl = quad[0] ? (QUARTER - rem) : rem;
  assign x_in = POLY_W'(refl) << (32 - ANGLE_BITS);

  assign sq = {{POLY_W{1'b0}}, x_q[0]} * {{POLY_W{1'b0}}, x_q[0]};

  // One Horner product a stage; the innermost step starts from C11
  for (genvar k = 0; k < POLY_TERMS; k++) begin : g_horner
    logic [POLY_W-1:0] p_in;
    if (k == 0) begin : g_first
      assign p_in = POLY_C11;
    end else begin : g_next
      assign p_in = p_q[k+1];
    end
    assign pr[k] = {{POLY_W{1'b0}}, z_q[k+1]} * {{POLY_W{1'b0}}, p_in};
  end

  assign fin = {{POLY_W{1'b0}}, x_q[6]} * {{POLY_W{1'b0}}, p_q[6]};
  assign rnd = {1'b0, s_q} + ((POLY_W+1)'(1) << (29 - F));
  assign mag = rnd[QSHIFT+1:QSHIFT-F];

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0]   <= x_in;
      neg_q[0] <= quad[1];
      z_q[1]   <= sq[2*POLY_W-2:QSHIFT];
      for (int k = 1; k <= POLY_TERMS + 1; k++) begin
        x_q[k] <= x_q[k-1];
      end
      for (int k = 1; k <= POLY_TERMS + 2; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
      for (int k = 2; k <= POLY_TERMS; k++) begin
        z_q[k] <= z_q[k-1];
      end
      for (int k = 0; k < POLY_TERMS; k++) begin
        p_q[k+2] <= poly_coef(k) - pr[k][QSHIFT+POLY_W-1:QSHIFT];
      end
      s_q  <= fin[QSHIFT+POLY_W-1:QSHIFT];
      sine <= neg_q[7] ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

[sv/trs_mm_entry.sv]
// Rotation-scale entries from six trig values and three scale factors,
// five register stages. Depends on trs_mm_pkg for field widths.
module trs_mm_entry #(
  parameter int TRIG_FRACTION_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [TRIG_FRACTION_BITS+1:0]  sx,
  input  logic signed [TRIG_FRACTION_BITS+1:0]  cx,
  input  logic signed [TRIG_FRACTION_BITS+1:0]  sy,
  input  logic signed [TRIG_FRACTION_BITS+1:0]  cy,
  input  logic signed [TRIG_FRACTION_BITS+1:0]  sz,
  input  logic signed [TRIG_FRACTION_BITS+1:0]  cz,
  input  logic [3*trs_mm_pkg::STRETCH_W-1:0]    stretch,
  output logic [trs_mm_pkg::MAT_W-1:0]          mat
);
  import trs_mm_pkg::*;

  localparam int F  = TRIG_FRACTION_BITS;
  localparam int TW = F + 2;
  localparam int W2 = 2 * TW;
  localparam int W3 = 3 * TW;
  localparam int RW = W3 + 2;
  localparam int QW = F + 3;
  localparam int MW = QW + STRETCH_W;
  localparam int EW = MW + 1;
  localparam logic signed [RW-1:0] HALF_R = RW'(1) <<< (2 * F - 1);
  localparam logic signed [EW-1:0] HALF_E = EW'(1) <<< (F - 1);
  localparam logic signed [EW-1:0] SAT_HI = EW'(32767);
  localparam logic signed [EW-1:0] SAT_LO = -EW'(32768);

  // Stage 1
  logic signed [W2-1:0] sxsy, cxsy, cycz, cysz, cxsz, cxcz, sxcy, sxsz, sxcz, cxcy;
  logic signed [TW-1:0] sy1, sz1, cz1;
  logic [3*STRETCH_W-1:0] k1, k2, k3;
  // Stage 2
  logic signed [W3-1:0] t1, t2, t3, t4;
  logic signed [W2-1:0] cycz2, cysz2, cxsz2, cxcz2, sxcy2, sxsz2, sxcz2, cxcy2;
  logic signed [TW-1:0] sy2;
  // Stages 3 to 5
  logic signed [RW-1:0]        r3    [0:8];
  logic signed [RW-1:0]        rr    [0:8];
  logic signed [QW-1:0]        r_q   [0:8];
  logic signed [MW-1:0]        m_q   [0:8];
  logic signed [STRETCH_W-1:0] k_v   [0:8];
  logic signed [ENTRY_W-1:0]   sat_v [0:8];

  always_ff @(posedge clk) begin
    if (en) begin
      sxsy <= sx * sy;  cxsy <= cx * sy;
      cycz <= cy * cz;  cysz <= cy * sz;
      cxsz <= cx * sz;  cxcz <= cx * cz;
      sxcy <= sx * cy;  sxsz <= sx * sz;
      sxcz <= sx * cz;  cxcy <= cx * cy;
      sy1 <= sy;  sz1 <= sz;  cz1 <= cz;
      k1 <= stretch;

      t1 <= sxsy * cz1;  t2 <= sxsy * sz1;
      t3 <= cxsy * cz1;  t4 <= cxsy * sz1;
      cycz2 <= cycz;  cysz2 <= cysz;  cxsz2 <= cxsz;  cxcz2 <= cxcz;
      sxcy2 <= sxcy;  sxsz2 <= sxsz;  sxcz2 <= sxcz;  cxcy2 <= cxcy;
      sy2 <= sy1;
      k2 <= k1;
      k3 <= k2;
    end
  end

  // Entries in Q(3F)
  always_comb begin
    r3[0] = RW'(cycz2) <<< F;
    r3[1] = -(RW'(cysz2) <<< F);
    r3[2] = RW'(sy2) <<< (2 * F);
    r3[3] = RW'(t1) + (RW'(cxsz2) <<< F);
    r3[4] = -RW'(t2) + (RW'(cxcz2) <<< F);
    r3[5] = -(RW'(sxcy2) <<< F);
    r3[6] = -RW'(t3) + (RW'(sxsz2) <<< F);
    r3[7] = RW'(t4) + (RW'(sxcz2) <<< F);
    r3[8] = RW'(cxcy2) <<< F;
  end

  for (genvar i = 0; i < 9; i++) begin : g_ent
    logic signed [EW-1:0] e;
    logic signed [EW-1:0] es;

    assign rr[i]    = r3[i] + HALF_R;
    assign k_v[i]   = $signed(k3[(i % 3) * STRETCH_W +: STRETCH_W]);
    assign e        = EW'(m_q[i]) + HALF_E;
    assign es       = e >>> F;
    assign sat_v[i] = (es > SAT_HI) ? ENTRY_W'(SAT_HI) :
                      (es < SAT_LO) ? ENTRY_W'(SAT_LO) : ENTRY_W'(es);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        r_q[i] <= rr[i][2*F +: QW];
        m_q[i] <= r_q[i] * k_v[i];
        mat[i*ENTRY_W +: ENTRY_W] <= sat_v[i];
      end
    end
  end

endmodule

[sim/trs_model_matrix_checker.sv]
// Checker for the TRS model matrix composer: watches both streams, predicts each
// matrix from the accepted input item and compares it field by field.
// Depends on trs_mm_pkg for the stream widths.
`timescale 1ns / 1ps
module trs_model_matrix_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [trs_mm_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [trs_mm_pkg::M_DATA_W-1:0] m_tdata,
  output int                              fail_count,
  output int                              pending,
  output int                              matrices_seen
);
  import trs_mm_pkg::*;

  localparam int ANG_BITS  = 16;
  localparam int FRAC_BITS = 14;

  logic [M_DATA_W-1:0] matrix_queue[$];

  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint quarter_sin(longint unsigned x);
    longint unsigned z, p;
    z = (x * x) >> 30;
    p = 64'd3864;
    p = 64'd172272 - ((z * p) >> 30);
    p = 64'd5026995 - ((z * p) >> 30);
    p = 64'd85569306 - ((z * p) >> 30);
    p = 64'd693598668 - ((z * p) >> 30);
    p = 64'd1686629713 - ((z * p) >> 30);
    return longint'((x * p) >> 30);
  endfunction

  function automatic longint angle_sin(longint unsigned a);
    longint unsigned quarter, q, r, s;
    quarter = 64'd1 << (ANG_BITS - 2);
    a = a & ((64'd1 << ANG_BITS) - 1);
    q = a >> (ANG_BITS - 2);
    r = a & (quarter - 1);
    if (q[0]) r = quarter - r;
    s = quarter_sin(r << (32 - ANG_BITS));
    s = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return (q >= 2) ? -longint'(s) : longint'(s);
  endfunction

  function automatic logic [15:0] scaled_entry(longint r3, longint k);
    longint r, e;
    r = round_half_up(r3, 2 * FRAC_BITS);
    e = round_half_up(r * k, FRAC_BITS);
    if (e > 32767) e = 32767;
    if (e < -32768) e = -32768;
    return e[15:0];
  endfunction

  function automatic logic [M_DATA_W-1:0] compose_matrix(logic [S_DATA_W-1:0] d);
    longint one, sx, cx, sy, cy, sz, cz, kx, ky, kz, sxsy, cxsy;
    longint unsigned quarter;
    logic [M_DATA_W-1:0] m;
    one = longint'(1) << FRAC_BITS;
    quarter = 64'd1 << (ANG_BITS - 2);
    sx = angle_sin(d[111:96]); cx = angle_sin(64'(d[111:96]) + quarter);
    sy = angle_sin(d[127:112]); cy = angle_sin(64'(d[127:112]) + quarter);
    sz = angle_sin(d[143:128]); cz = angle_sin(64'(d[143:128]) + quarter);
    kx = longint'($signed(d[159:144]));
    ky = longint'($signed(d[175:160]));
    kz = longint'($signed(d[191:176]));
    sxsy = sx * sy;
    cxsy = cx * sy;
    m[15:0]    = scaled_entry(cy * cz * one, kx);
    m[31:16]   = scaled_entry(-(cy * sz) * one, ky);
    m[47:32]   = scaled_entry(sy * one * one, kz);
    m[63:48]   = scaled_entry(sxsy * cz + cx * sz * one, kx);
    m[79:64]   = scaled_entry(-(sxsy * sz) + cx * cz * one, ky);
    m[95:80]   = scaled_entry(-(sx * cy) * one, kz);
    m[111:96]  = scaled_entry(-(cxsy * cz) + sx * sz * one, kx);
    m[127:112] = scaled_entry(cxsy * sz + sx * cz * one, ky);
    m[143:128] = scaled_entry(cx * cy * one, kz);
    m[239:144] = d[95:0];
    return m;
  endfunction

  task automatic report(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    matrices_seen = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    logic [M_DATA_W-1:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready) matrix_queue.push_back(compose_matrix(s_tdata));
      if (m_tvalid && m_tready) begin
        matrices_seen++;
        if (matrix_queue.size() == 0) begin
          report("matrix with no input item waiting");
        end else begin
          want = matrix_queue.pop_front();
          for (int f = 0; f < 9; f++)
            if (m_tdata[16*f +: 16] !== want[16*f +: 16])
              report($sformatf("entry r%0d c%0d got %h want %h", f / 3, f % 3,
                               m_tdata[16*f +: 16], want[16*f +: 16]));
          for (int f = 0; f < 3; f++)
            if (m_tdata[144 + 32*f +: 32] !== want[144 + 32*f +: 32])
              report($sformatf("offset %0d got %h want %h", f,
                               m_tdata[144 + 32*f +: 32], want[144 + 32*f +: 32]));
        end
      end
    end
    pending = matrix_queue.size();
  end

endmodule

[sim/trs_model_matrix_composer_tb.sv]
// Testbench top for the TRS model matrix composer: makes clock, reset and stimulus,
// stalls the result stream, and gives the verdict. Depends on trs_mm_pkg, the block
// and trs_model_matrix_checker.
`timescale 1ns / 1ps
module trs_model_matrix_composer_tb;
  import trs_mm_pkg::*;

  localparam int PIPE_DEPTH     = SIN_LAT + ENT_LAT;
  localparam int DIRECTED_ITEMS = 13;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  int fail_count, pending, matrices_seen;
  int hold_off = 0;  // cycles left in the long receiver stall
  bit hold_done = 1'b0;
  int items_sent = 0;

  always #2 clk = ~clk;

  trs_model_matrix_composer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  trs_model_matrix_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending), .matrices_seen(matrices_seen)
  );

  // Receiver: mostly random stalls, free-running stretches, and one long hold-off
  // that starts once the directed items are in.
  always @(posedge clk) begin
    int phase;
    phase = $urandom_range(0, 99);
    if (!hold_done && items_sent >= DIRECTED_ITEMS) begin
      hold_done <= 1'b1;
      hold_off  <= 3 * PIPE_DEPTH;
      m_tready  <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else if ((items_sent / 100) % 3 == 0) begin
      m_tready <= 1'b1;  // stretch with no stalls
    end else begin
      m_tready <= (phase < 65);
    end
  end

  // Bias a field towards its extremes now and then.
  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h1000;  // unit scale
      3: return 16'hf000;
      4: return 16'h0;
      5: return 16'hffff;
      6: return 16'h4000;  // quarter turn as an angle
      7: return 16'hc000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until it is taken.
  task automatic send_item(logic [S_DATA_W-1:0] d);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [S_DATA_W-1:0] pack_item(
    logic [31:0] tx, ty, tz, logic [15:0] ax, ay, az, kx, ky, kz);
    return {kz, ky, kx, az, ay, ax, tz, ty, tx};
  endfunction

  task automatic pause_sender();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] ang;
    int burst;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: quadrant boundaries, odd quadrants, extreme scales and shifts.
    for (int q = 0; q < 8; q++) begin
      ang = 16'(q * 16'h2000);
      send_item(pack_item(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000,
                          ang, 16'(ang + 16'h0800), 16'(16'hffff - ang),
                          16'h1000, 16'h7fff, 16'h8000));
    end
    send_item(pack_item('0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_item(pack_item('1, '1, '1, '1, '1, '1, '1, '1, '1));
    send_item(pack_item(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                        16'h4000, 16'h4000, 16'h4000, 16'h7fff, 16'h7fff, 16'h7fff));
    send_item(pack_item(32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f,
                        16'h2000, 16'h6000, 16'ha000, 16'h8000, 16'h8000, 16'h8000));
    send_item(pack_item(32'h5555_5555, 32'haaaa_aaaa, 32'h0,
                        16'h0001, 16'h3fff, 16'h8001, 16'h0001, 16'hffff, 16'h1000));

    // Long receiver hold-off while the sender keeps offering: fills the pipe.
    for (int i = 0; i < 30; i++) send_item({pick16(), pick16(), pick16(), pick16(),
                                            pick16(), pick16(), pick32(), pick32(),
                                            pick32()});
    // Pause until every expected matrix has come.
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Random bursts with random gaps.
    while (items_sent < 800) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst; i++)
        send_item({pick16(), pick16(), pick16(), pick16(), pick16(), pick16(),
                   pick32(), pick32(), pick32()});
      if ($urandom_range(0, 3) != 0)
        repeat ($urandom_range(1, 6)) pause_sender();
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    $display("Sent %0d transform items, checked %0d matrices, across quadrant edges,",
             items_sent, matrices_seen);
    $display("saturating scales, back-pressure and sender gaps.");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
sv/trs_mm_pkg.sv
sv/trs_mm_sine.sv
sv/trs_mm_entry.sv
sv/trs_model_matrix_composer.sv
sim/trs_model_matrix_checker.sv
sim/trs_model_matrix_composer_tb.sv
